FILE: rtl/linear_probe_hash_set_top_assert.svh
// Assertion macros for the linear-probe hash set RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef LINEAR_PROBE_HASH_SET_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LPHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lphs check failed");

// Next-cycle implication, disabled while reset is low.
`define LPHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lphs check failed");

`endif

FILE: rtl/lphs_pkg.sv
// Shared types and constants for the linear-probe hash set.
// No dependencies; imported by the cell, the controller and the top level.
package lphs_pkg;

  localparam int KEY_W         = 64;
  localparam int LEN_W         = 4;
  localparam int STATUS_W      = 3;
  localparam int SLOT_W        = 5;
  localparam int MAX_KEY_CHARS = 8;
  localparam int KEY_BYTES     = KEY_W / 8;
  localparam int CHAR_LOW      = 97;
  localparam int CHAR_SPAN     = 26;
  localparam int CODE_W        = 5;
  localparam int CODE_DEPTH    = 1 << CODE_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_BADKEY   = 3'd5
  } status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PROBE = 1'b1
  } state_e;

  // Controller to cells: token moves and slot updates.
  typedef struct packed {
    logic             load;
    logic             advance;
    logic             drop;
    logic             store;
    logic             clear;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } lphs_ctrl_t;

  // Cell to controller: what the token-holding slot shows.
  typedef struct packed {
    logic used;
    logic match;
  } lphs_flags_t;

endpackage

FILE: rtl/lphs_cell.sv
// One slot of the hash set: used bit, stored key, and the probe token.
// Depends on lphs_pkg for the control and flag structs.
module lphs_cell import lphs_pkg::*; #(
  parameter int IDX_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lphs_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]  home_i,
  input  logic              tok_i,
  output logic              tok_o,
  output lphs_flags_t       flags_o
);

  logic             tok_q, tok_d;
  logic             used_q, used_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [KEY_W-1:0] key_q;

  // Place the token at the home slot, pass it on, or drop it
  always_comb begin
    tok_d = tok_q;
    if (ctrl_i.load) begin
      tok_d = (home_i == IDX_W'(CELL_IDX));
    end else if (ctrl_i.advance) begin
      tok_d = tok_i;
    end else if (ctrl_i.drop) begin
      tok_d = 1'b0;
    end
  end

  // Store or release the slot when it holds the token
  always_comb begin
    used_d = used_q;
    len_d  = len_q;
    if (tok_q && ctrl_i.store) begin
      used_d = 1'b1;
      len_d  = ctrl_i.len;
    end else if (tok_q && ctrl_i.clear) begin
      used_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      used_q <= 1'b0;
      len_q  <= '0;
    end else begin
      tok_q  <= tok_d;
      used_q <= used_d;
      len_q  <= len_d;
    end
  end

  // Key bytes need no reset: a zero length never matches
  always_ff @(posedge clk_i) begin
    if (tok_q && ctrl_i.store) begin
      key_q <= ctrl_i.key;
    end
  end

  assign tok_o         = tok_q;
  assign flags_o.used  = tok_q & used_q;
  assign flags_o.match = tok_q & (len_q == ctrl_i.len) & (key_q == ctrl_i.key);

endmodule

FILE: rtl/lphs_ctrl.sv
// Command decode and probe sequencer for the linear-probe hash set.
// Depends on lphs_pkg; drives the cell row and the result register.
module lphs_ctrl import lphs_pkg::*; #(
  parameter int SLOT_COUNT = 26,
  parameter int IDX_W      = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [KEY_W-1:0]    key_chars_i,
  input  logic [LEN_W-1:0]    key_len_i,
  input  lphs_flags_t         flags_i,
  output lphs_ctrl_t          ctrl_o,
  output logic [IDX_W-1:0]    home_o,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_o
);

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  logic [IDX_W-1:0]     steps_q, steps_d;
  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;

  logic [KEY_W-1:0]     key_masked;
  logic [7:0]           last_char;
  logic                 len_ok, char_ok;
  logic [CODE_W-1:0]    char_code;
  logic [IDX_W-1:0]     home_tab [CODE_DEPTH];
  logic                 last_step;

  // Home slot table: letter code modulo the slot count
  for (genvar c = 0; c < CODE_DEPTH; c++) begin : g_home
    localparam int HOME_C = (c < CHAR_SPAN) ? (c % SLOT_COUNT) : 0;
    assign home_tab[c] = IDX_W'(HOME_C);
  end

  // Mask stray bytes and pick the last character
  always_comb begin
    key_masked = '0;
    last_char  = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LEN_W'(b) < key_len_i) begin
        key_masked[8*b +: 8] = key_chars_i[8*b +: 8];
      end
      if (LEN_W'(b + 1) == key_len_i) begin
        last_char = key_chars_i[8*b +: 8];
      end
    end
  end

  assign len_ok    = (key_len_i != '0) && (key_len_i <= LEN_W'(MAX_KEY_CHARS));
  assign char_ok   = (last_char >= 8'(CHAR_LOW)) && (last_char < 8'(CHAR_LOW + CHAR_SPAN));
  assign char_code = CODE_W'(last_char - 8'(CHAR_LOW));
  assign home_o    = home_tab[char_code];
  assign last_step = (steps_q == IDX_W'(SLOT_COUNT - 1));

  // Next state, token control and result
  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    key_d          = key_q;
    len_d          = len_q;
    cur_d          = cur_q;
    steps_d        = steps_q;
    done_d         = 1'b0;
    status_d       = status_q;
    slot_d         = slot_q;
    ctrl_o         = '0;
    ctrl_o.key     = key_q;
    ctrl_o.len     = len_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (!(len_ok && char_ok)) begin
            done_d   = 1'b1;
            status_d = ST_BADKEY;
            slot_d   = '0;
          end else begin
            ctrl_o.load = 1'b1;
            cmd_d       = cmd_e'(cmd_i);
            key_d       = key_masked;
            len_d       = key_len_i;
            cur_d       = home_o;
            steps_d     = '0;
            state_d     = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (cmd_q == CMD_INSERT && !flags_i.used) begin
          ctrl_o.store = 1'b1;
          ctrl_o.drop  = 1'b1;
          done_d       = 1'b1;
          status_d     = ST_INSERTED;
          slot_d       = SLOT_W'(cur_q);
          state_d      = S_IDLE;
        end else if (flags_i.match) begin
          ctrl_o.drop = 1'b1;
          done_d      = 1'b1;
          state_d     = S_IDLE;
          if (cmd_q == CMD_INSERT) begin
            status_d = ST_PRESENT;
            slot_d   = SLOT_W'(cur_q);
          end else if (flags_i.used) begin
            ctrl_o.clear = 1'b1;
            status_d     = ST_DELETED;
            slot_d       = SLOT_W'(cur_q);
          end else begin
            status_d = ST_ABSENT;
            slot_d   = '0;
          end
        end else if (last_step) begin
          ctrl_o.drop = 1'b1;
          done_d      = 1'b1;
          status_d    = (cmd_q == CMD_INSERT) ? ST_FULL : ST_ABSENT;
          slot_d      = '0;
          state_d     = S_IDLE;
        end else begin
          ctrl_o.advance = 1'b1;
          cur_d          = (cur_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : cur_q + 1'b1;
          steps_d        = steps_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Command payload and result fields hold without reset
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    len_q    <= len_d;
    cur_q    <= cur_d;
    steps_q  <= steps_d;
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  assign busy     = (state_q == S_PROBE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign slot_o   = slot_q;

endmodule

FILE: rtl/linear_probe_hash_set_top.sv
// Linear-probe hash set: a ring of slot cells walked by a probe token.
// Depends on lphs_pkg, lphs_cell, lphs_ctrl and the assertion macro header.
//
//   channel   | ports                                  | handshake
//   ----------+----------------------------------------+----------------------------
//   command   | cmd_i, key_chars_i, key_len_i          | transfer on start && !busy
//   result    | status_o, slot_o                       | done_o strobe, one cycle
//
// A bad key returns its result on the cycle after the command transfer.
// A valid key visits one slot per cycle from its home slot: from one slot up to
// SLOT_COUNT slots, with busy high while it probes and the result on the next cycle.
// The next command may transfer while that result is on the ports.
// Reset clears every used bit and stored length at once; no clearing pass.
// The receiver cannot stall: each result is valid for exactly one cycle.
`include "linear_probe_hash_set_top_assert.svh"

module linear_probe_hash_set_top import lphs_pkg::*; #(
  parameter int SLOT_COUNT = 26
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [KEY_W-1:0]    key_chars_i,
  input  logic [LEN_W-1:0]    key_len_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_o
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  lphs_ctrl_t              ctrl;
  logic [IDX_W-1:0]        home;
  logic [SLOT_COUNT-1:0]   tok;
  lphs_flags_t             cell_flags [SLOT_COUNT];
  lphs_flags_t             flags;

  // Ring of slot cells; the token moves from each cell to the next
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    localparam int PREV = (i + SLOT_COUNT - 1) % SLOT_COUNT;
    lphs_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .home_i  (home),
      .tok_i   (tok[PREV]),
      .tok_o   (tok[i]),
      .flags_o (cell_flags[i])
    );
  end

  // Merge the flags; only the token holder drives them
  always_comb begin
    flags = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      flags.used  = flags.used  | cell_flags[i].used;
      flags.match = flags.match | cell_flags[i].match;
    end
  end

  lphs_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .key_chars_i (key_chars_i),
    .key_len_i   (key_len_i),
    .flags_i     (flags),
    .ctrl_o      (ctrl),
    .home_o      (home),
    .done_o      (done_o),
    .status_o    (status_o),
    .slot_o      (slot_o)
  );

  // Exactly one token while probing, none otherwise
  `LPHS_ASSERT_NOW(a_tok_onehot, clk_i, rst_ni, busy, $onehot(tok))
  `LPHS_ASSERT_NOW(a_tok_idle, clk_i, rst_ni, !busy, tok == '0)
  // Failed lookups and bad keys report slot zero
  `LPHS_ASSERT_NOW(a_slot_zero, clk_i, rst_ni,
    done_o && (status_o == ST_FULL || status_o == ST_ABSENT || status_o == ST_BADKEY),
    slot_o == '0)
  // A probe that ends drops the token in the same edge
  `LPHS_ASSERT_NEXT(a_probe_end, clk_i, rst_ni, busy && ctrl.drop, !busy && done_o)

endmodule

FILE: test/tb.sv
// Testbench for linear_probe_hash_set_top: directed and random insert/delete traffic.
// A local probe predictor expects each result, and a monitor checks every done_o strobe.
// Depends on lphs_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb import lphs_pkg::*;;

  localparam int SLOT_COUNT = 26;
  localparam int POOL_SIZE  = 40;

  typedef struct {
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } probe_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cmd_i;
  logic [KEY_W-1:0]    key_chars_i;
  logic [LEN_W-1:0]    key_len_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_o;

  // Predictor copy of the table
  logic                tbl_used [SLOT_COUNT];
  logic [KEY_W-1:0]    tbl_key  [SLOT_COUNT];
  logic [LEN_W-1:0]    tbl_len  [SLOT_COUNT];

  probe_result_t       pending_results[$];
  probe_result_t       head_result;
  int                  err_count;
  int                  idle_pct;

  // Key pool for random traffic
  logic [KEY_W-1:0]    pool_chars [POOL_SIZE];
  logic [LEN_W-1:0]    pool_len   [POOL_SIZE];

  linear_probe_hash_set_top #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .key_chars_i (key_chars_i),
    .key_len_i   (key_len_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .slot_o      (slot_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("linear_probe_hash_set_top verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Probe the local table the way the block does and update it
  function automatic probe_result_t predict_probe(input cmd_e cmd, input logic [KEY_W-1:0] chars,
                                                  input logic [LEN_W-1:0] len);
    probe_result_t res;
    logic [KEY_W-1:0] key;
    logic [7:0] last;
    int n, home, s, i;
    res.status = ST_BADKEY;
    res.slot   = '0;
    n = int'(len);
    if (n == 0 || n > MAX_KEY_CHARS) return res;
    key  = (n >= KEY_BYTES) ? chars : (chars & ((64'd1 << (8 * n)) - 64'd1));
    last = 8'(key >> (8 * (n - 1)));
    if (last < CHAR_LOW || last >= CHAR_LOW + CHAR_SPAN) return res;
    home = (int'(last) - CHAR_LOW) % SLOT_COUNT;
    if (cmd == CMD_INSERT) begin
      for (i = 0; i < SLOT_COUNT; i++) begin
        s = (home + i) % SLOT_COUNT;
        if (!tbl_used[s]) begin
          tbl_used[s] = 1'b1;
          tbl_key[s]  = key;
          tbl_len[s]  = len;
          res.status  = ST_INSERTED;
          res.slot    = SLOT_W'(s);
          return res;
        end
        if (tbl_len[s] == len && tbl_key[s] == key) begin
          res.status = ST_PRESENT;
          res.slot   = SLOT_W'(s);
          return res;
        end
      end
      res.status = ST_FULL;
      return res;
    end
    // Delete: first stored match wins, used or not
    for (i = 0; i < SLOT_COUNT; i++) begin
      s = (home + i) % SLOT_COUNT;
      if (tbl_len[s] == len && tbl_key[s] == key) begin
        if (tbl_used[s]) begin
          tbl_used[s] = 1'b0;
          res.status  = ST_DELETED;
          res.slot    = SLOT_W'(s);
        end else begin
          res.status = ST_ABSENT;
        end
        return res;
      end
    end
    res.status = ST_ABSENT;
    return res;
  endfunction

  // Lowercase key of n_chars characters ending in last
  function automatic logic [KEY_W-1:0] rand_word(input int n_chars, input logic [7:0] last);
    logic [KEY_W-1:0] w;
    int i;
    w = '0;
    for (i = 0; i < n_chars - 1; i++) w[8*i +: 8] = 8'(CHAR_LOW + $urandom_range(CHAR_SPAN - 1));
    w[8*(n_chars-1) +: 8] = last;
    return w;
  endfunction

  // Send one command, optionally after an idle gap, and record its expected result
  task automatic send_cmd(input cmd_e cmd, input logic [KEY_W-1:0] chars,
                          input logic [LEN_W-1:0] len);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= cmd;
    key_chars_i <= chars;
    key_len_i   <= len;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_probe(cmd, chars, len));
  endtask

  // Hold off the sender until every pending result is back
  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Bad keys, stray bytes, wrap-around, delete of an unused match, reuse of a freed slot
  task automatic test_directed();
    idle_pct = 0;
    send_cmd(CMD_INSERT, {$urandom, $urandom}, 4'd0);
    send_cmd(CMD_INSERT, 64'h6161_6161_6161_6161, 4'd9);
    send_cmd(CMD_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    send_cmd(CMD_INSERT, 64'h41, 4'd1);
    send_cmd(CMD_INSERT, 64'h7B61, 4'd2);
    send_cmd(CMD_DELETE, 64'h60, 4'd1);
    send_cmd(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF61, 4'd1);
    send_cmd(CMD_INSERT, 64'h61, 4'd1);
    send_cmd(CMD_INSERT, 64'h7A, 4'd1);
    send_cmd(CMD_INSERT, 64'h7A61, 4'd2);
    send_cmd(CMD_INSERT, 64'h7A7A_7A7A_7A7A_7A7A, 4'd8);
    send_cmd(CMD_DELETE, 64'h61, 4'd1);
    send_cmd(CMD_DELETE, 64'h61, 4'd1);
    send_cmd(CMD_DELETE, 64'h7A61, 4'd2);
    send_cmd(CMD_DELETE, 64'h71, 4'd1);
    send_cmd(CMD_INSERT, 64'h7A61, 4'd2);
    send_cmd(CMD_DELETE, 64'h7A7A_7A7A_7A7A_7A7A, 4'd8);
    send_cmd(CMD_INSERT, 64'hA5A5_A5A5_A5A5_A562, 4'd1);
    hold_until_drained();
    send_cmd(CMD_INSERT, 64'h61, 4'd1);
    send_cmd(CMD_DELETE, 64'h0000_0000_0000_FF62, 4'd1);
  endtask

  // Fill past capacity, hit present after long probes, then empty the table
  task automatic test_full_table();
    logic [KEY_W-1:0] fill_key [30];
    int i, j;
    idle_pct = 23;
    for (i = 0; i < 30; i++) begin
      fill_key[i] = {40'd0, 8'(CHAR_LOW + $urandom_range(CHAR_SPAN - 1)),
                     8'(CHAR_LOW + i / CHAR_SPAN), 8'(CHAR_LOW + i % CHAR_SPAN)};
      send_cmd(CMD_INSERT, fill_key[i], 4'd3);
    end
    for (i = 0; i < 6; i++) send_cmd(CMD_INSERT, fill_key[$urandom_range(29)], 4'd3);
    hold_until_drained();
    for (i = 0; i < 30; i++) begin
      j = (i * 7) % 30;
      send_cmd(CMD_DELETE, fill_key[j], 4'd3);
    end
    send_cmd(CMD_DELETE, 64'h7A, 4'd1);
    send_cmd(CMD_DELETE, 64'h7A61, 4'd2);
    send_cmd(CMD_DELETE, 64'h62, 4'd1);
    send_cmd(CMD_DELETE, 64'h61, 4'd1);
  endtask

  // Random insert/delete traffic over a small key pool, with some bad keys
  task automatic test_random_mix(input int n_items, input int pct);
    logic [KEY_W-1:0] chars;
    logic [LEN_W-1:0] len;
    logic [7:0] last;
    cmd_e cmd;
    int i, r, k, n;
    idle_pct = pct;
    for (i = 0; i < POOL_SIZE; i++) begin
      n    = $urandom_range(1, MAX_KEY_CHARS);
      last = ($urandom_range(1) == 0) ? 8'(CHAR_LOW + $urandom_range(7))
                                      : 8'(CHAR_LOW + $urandom_range(CHAR_SPAN - 1));
      pool_chars[i] = rand_word(n, last);
      pool_len[i]   = LEN_W'(n);
    end
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        chars = {$urandom, $urandom};
        case ($urandom_range(2))
          0: len = '0;
          1: len = LEN_W'($urandom_range(MAX_KEY_CHARS + 1, 15));
          default: begin
            n    = $urandom_range(1, MAX_KEY_CHARS);
            last = ($urandom_range(1) == 0) ? 8'($urandom_range(CHAR_LOW - 1))
                                            : 8'($urandom_range(CHAR_LOW + CHAR_SPAN, 255));
            chars[8*(n-1) +: 8] = last;
            len = LEN_W'(n);
          end
        endcase
        cmd = ($urandom_range(1) == 0) ? CMD_INSERT : CMD_DELETE;
      end else begin
        k     = $urandom_range(POOL_SIZE - 1);
        chars = pool_chars[k];
        len   = pool_len[k];
        // Fill the bytes beyond the key with junk now and then
        if (len < MAX_KEY_CHARS && $urandom_range(4) == 0)
          chars = chars | ({$urandom, $urandom} << (8 * len));
        cmd = (r < 62) ? CMD_INSERT : CMD_DELETE;
      end
      send_cmd(cmd, chars, len);
    end
  endtask

  // Check each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d slot %0d", status_o, slot_o));
      end else begin
        head_result = pending_results.pop_front();
        if (status_o !== head_result.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, head_result.status));
        if (slot_o !== head_result.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", slot_o, head_result.slot));
      end
    end
  end

  initial begin
    int i;
    err_count   = 0;
    idle_pct    = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cmd_i       <= 1'b0;
    key_chars_i <= '0;
    key_len_i   <= '0;
    for (i = 0; i < SLOT_COUNT; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_len[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_random_mix(100, 0);
    test_random_mix(100, 52);
    test_random_mix(90, 23);
    test_random_mix(70, 0);

    // Drain, then watch a little longer for stray strobes
    hold_until_drained();
    repeat (SLOT_COUNT + 4) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("linear_probe_hash_set_top verification clean");
    end else begin
      $display("linear_probe_hash_set_top verification failed");
    end
    $finish;
  end

endmodule
